// File: sv/bfv_pkg.sv
// Shared types, widths and plane tables for the box frustum visibility test.
package bfv_pkg;

	// Fixed-point format of the matrix entries.
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS = 16;

	// Input and configuration widths.
	localparam int IN_W = 32;
	localparam int SIZE_W = 31;
	localparam int CFG_W = 64;
	localparam int HALF_W = 32;
	localparam int NUM_CFG = 8;
	localparam int CFG_IDX_W = $clog2(NUM_CFG);

	// Matrix and plane geometry.
	localparam int MAT_DIM = 4;
	localparam int NUM_ENTRIES = MAT_DIM * MAT_DIM;
	localparam int NUM_AXES = 3;
	localparam int NUM_PLANES = 6;
	localparam int BASE_ROW = 3;

	// Internal arithmetic widths; every sum and product is exact.
	localparam int CORNER_W = IN_W + 1;
	localparam int COEF_W = WORD_WIDTH + 1;
	localparam int PROD_W = COEF_W + CORNER_W;
	localparam int ACC_W = PROD_W + 2;

	typedef logic signed [WORD_WIDTH-1:0] entry_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [CORNER_W-1:0] corner_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// How a plane row is formed from row 3 and one other row.
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_BASE
	} plane_op_t;

	// One box as it travels down the chain of plane cells.
	typedef struct packed {
		logic valid;
		logic visible;
		corner_t [NUM_AXES-1:0] lo;
		corner_t [NUM_AXES-1:0] hi;
	} box_t;

	// Plane rows: R3+R1, R3-R1, R3+R0, R3-R0, R3-R2 and R3 alone.
	localparam int PLANE_ROW [NUM_PLANES] = '{1, 1, 0, 0, 2, 0};
	localparam plane_op_t PLANE_OP [NUM_PLANES] =
		'{OP_ADD, OP_SUB, OP_ADD, OP_SUB, OP_SUB, OP_BASE};

endpackage

// File: sv/bfv_cell.sv
// One plane cell: tests the passing box against a single frustum plane.
module bfv_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bfv_pkg::entry_t     base_col [bfv_pkg::MAT_DIM],
	input  bfv_pkg::entry_t     other_col [bfv_pkg::MAT_DIM],
	input  bfv_pkg::plane_op_t  op,
	input  bfv_pkg::box_t       box_in,
	output bfv_pkg::box_t       box_out
);

	bfv_pkg::coef_t   coef_d [bfv_pkg::MAT_DIM];
	bfv_pkg::coef_t   coef_q [bfv_pkg::MAT_DIM];
	bfv_pkg::corner_t corner_sel [bfv_pkg::NUM_AXES];
	bfv_pkg::prod_t   prod_s1 [bfv_pkg::NUM_AXES];
	bfv_pkg::acc_t    w_s1;
	bfv_pkg::acc_t    sum_a_s2;
	bfv_pkg::acc_t    sum_b_s2;
	bfv_pkg::acc_t    total;
	bfv_pkg::box_t    box_s1;
	bfv_pkg::box_t    box_s2;
	bfv_pkg::box_t    box_s3;

	// Plane coefficients from row 3 and the selected row of each column.
	always_comb begin
		for (int i = 0; i < bfv_pkg::MAT_DIM; i++) begin
			unique case (op)
				bfv_pkg::OP_ADD:  coef_d[i] = bfv_pkg::coef_t'(base_col[i]) +
					bfv_pkg::coef_t'(other_col[i]);
				bfv_pkg::OP_SUB:  coef_d[i] = bfv_pkg::coef_t'(base_col[i]) -
					bfv_pkg::coef_t'(other_col[i]);
				bfv_pkg::OP_BASE: coef_d[i] = bfv_pkg::coef_t'(base_col[i]);
				default:          coef_d[i] = bfv_pkg::coef_t'(base_col[i]);
			endcase
		end
	end

	// The coefficients are held so that the multipliers start from a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bfv_pkg::MAT_DIM; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			coef_q <= coef_d;
		end
	end

	// Pick the corner furthest along the plane normal, axis by axis.
	always_comb begin
		for (int i = 0; i < bfv_pkg::NUM_AXES; i++) begin
			corner_sel[i] = (coef_q[i] > bfv_pkg::coef_t'(0)) ? box_in.hi[i] : box_in.lo[i];
		end
	end

	// Stage 1: one product per axis, and the plane offset scaled to match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s1 <= '0;
		end else begin
			box_s1 <= box_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < bfv_pkg::NUM_AXES; i++) begin
			prod_s1[i] <= bfv_pkg::prod_t'(coef_q[i]) * bfv_pkg::prod_t'(corner_sel[i]);
		end
		w_s1 <= bfv_pkg::acc_t'(coef_q[bfv_pkg::BASE_ROW]) <<< bfv_pkg::FRAC_BITS;
	end

	// Stage 2: two partial sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s2 <= '0;
		end else begin
			box_s2 <= box_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_a_s2 <= bfv_pkg::acc_t'(prod_s1[0]) + bfv_pkg::acc_t'(prod_s1[1]);
		sum_b_s2 <= bfv_pkg::acc_t'(prod_s1[2]) + w_s1;
	end

	// Stage 3: a negative total means the box lies wholly outside this plane.
	assign total = sum_a_s2 + sum_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s3 <= '0;
		end else begin
			box_s3.valid <= box_s2.valid;
			box_s3.lo <= box_s2.lo;
			box_s3.hi <= box_s2.hi;
			box_s3.visible <= box_s2.visible & ~total[bfv_pkg::ACC_W-1];
		end
	end

	assign box_out = box_s3;

endmodule

// File: sv/box_frustum_visibility_test.sv
// Top level of the box frustum visibility test: configuration, box entry and the plane chain.
//
// Usage:
//   A box transaction is accepted at a rising edge with start high and busy low.
//   busy is never raised, so one box may be started in every cycle.
//   The matrix is loaded through the cfg_valid / cfg_ready channel; cfg_index picks
//   one of eight 64-bit registers holding two Q16.16 entries each. cfg_ready is
//   always high. The user must write registers only while no box is in flight;
//   the block does not enforce this. The result appears on visible with done high
//   for exactly one cycle; results leave in the order the boxes were accepted.
//   Throughput is one box per cycle. A box passes through an input register,
//   a corner register and a chain of six plane cells of three stages each
//   (multiply, partial sums, final sum and sign).
//   Each cell recomputes its plane coefficients into a register in the cycle after
//   a configuration write.
//   Reset clears the matrix to zero and empties the pipeline.
//   The receiver cannot stall: done is a strobe and must be taken when it shows.
module box_frustum_visibility_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [bfv_pkg::IN_W-1:0] box_min_x,
	input  logic signed [bfv_pkg::IN_W-1:0] box_min_y,
	input  logic signed [bfv_pkg::IN_W-1:0] box_min_z,
	input  logic [bfv_pkg::SIZE_W-1:0]      box_size_x,
	input  logic [bfv_pkg::SIZE_W-1:0]      box_size_y,
	input  logic [bfv_pkg::SIZE_W-1:0]      box_size_z,
	output logic                            done,
	output logic                            visible,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfv_pkg::CFG_W-1:0]       cfg_data
);

	logic [bfv_pkg::CFG_W-1:0]       mat_q [bfv_pkg::NUM_CFG];
	bfv_pkg::entry_t                 entry [bfv_pkg::NUM_ENTRIES];
	logic                            valid_s0;
	logic signed [bfv_pkg::IN_W-1:0] min_s0 [bfv_pkg::NUM_AXES];
	logic [bfv_pkg::SIZE_W-1:0]      size_s0 [bfv_pkg::NUM_AXES];
	bfv_pkg::box_t                   box_s1;
	bfv_pkg::box_t                   chain [bfv_pkg::NUM_PLANES + 1];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Matrix registers, written one 64-bit word per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bfv_pkg::NUM_CFG; i++) begin
				mat_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// Each entry is a whole 32-bit half of its register, sign included.
	for (genvar e = 0; e < bfv_pkg::NUM_ENTRIES; e++) begin : g_entry
		assign entry[e] = mat_q[e / 2][(e % 2) * bfv_pkg::HALF_W +: bfv_pkg::WORD_WIDTH];
	end

	// Input register for an accepted box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		min_s0[0] <= box_min_x;
		min_s0[1] <= box_min_y;
		min_s0[2] <= box_min_z;
		size_s0[0] <= box_size_x;
		size_s0[1] <= box_size_y;
		size_s0[2] <= box_size_z;
	end

	// Low and high corners, exact in one extra bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s1 <= '0;
		end else begin
			box_s1.valid <= valid_s0;
			box_s1.visible <= 1'b1;
			for (int i = 0; i < bfv_pkg::NUM_AXES; i++) begin
				box_s1.lo[i] <= bfv_pkg::corner_t'(min_s0[i]);
				box_s1.hi[i] <= bfv_pkg::corner_t'(min_s0[i]) + bfv_pkg::corner_t'(size_s0[i]);
			end
		end
	end

	assign chain[0] = box_s1;

	// Chain of plane cells; each one clears the visible flag if its plane rejects.
	for (genvar p = 0; p < bfv_pkg::NUM_PLANES; p++) begin : g_plane
		bfv_pkg::entry_t base_col [bfv_pkg::MAT_DIM];
		bfv_pkg::entry_t other_col [bfv_pkg::MAT_DIM];

		for (genvar c = 0; c < bfv_pkg::MAT_DIM; c++) begin : g_col
			assign base_col[c] = entry[bfv_pkg::MAT_DIM * c + bfv_pkg::BASE_ROW];
			assign other_col[c] = entry[bfv_pkg::MAT_DIM * c + bfv_pkg::PLANE_ROW[p]];
		end

		bfv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.base_col  (base_col),
			.other_col (other_col),
			.op        (bfv_pkg::PLANE_OP[p]),
			.box_in    (chain[p]),
			.box_out   (chain[p + 1])
		);
	end

	// Result strobe and flag straight from the last cell.
	assign done = chain[bfv_pkg::NUM_PLANES].valid;
	assign visible = chain[bfv_pkg::NUM_PLANES].visible;

endmodule
